>>> rtl/utf8d_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 decoder.
`timescale 1ns / 1ps

package utf8d_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
    localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;

    // One decoded character: a single unit, or a surrogate pair (high in unit0).
    typedef struct packed {
        logic        pair;
        logic [15:0] unit0;
        logic [15:0] unit1;
    } job_t;

endpackage

>>> rtl/utf8d_front.sv
// Front end: accepts UTF-8 bytes, tracks the pending sequence and builds code units.
`timescale 1ns / 1ps

module utf8d_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] in_byte
    input  logic                full,
    output logic                push,
    output utf8d_pkg::job_t     push_job
);

    logic [1:0]  need_reg, need_next;
    logic [1:0]  len_reg, len_next;
    logic [20:0] bits_reg, bits_next;

    logic        accept;
    logic        emit;
    logic [20:0] bits_cat;
    logic [1:0]  need_dec;
    logic [4:0]  plane;
    logic [9:0]  plane_m1;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    assign bits_cat = {bits_reg[14:0], s_tdata[5:0]};
    assign need_dec = need_reg - 2'd1;
    assign plane    = bits_cat[20:16];
    assign plane_m1 = {5'd0, plane} - 10'd1;

    always_comb
    begin
        need_next = need_reg;
        len_next  = len_reg;
        bits_next = bits_reg;
        emit      = 1'b0;
        push_job  = '0;
        if (need_reg != 2'd0 && s_tdata[7:6] == 2'b10)
        begin
            // continuation byte of a pending sequence
            if (need_dec != 2'd0)
            begin
                need_next = need_dec;
                bits_next = bits_cat;
            end
            else
            begin
                need_next = 2'd0;
                len_next  = 2'd0;
                bits_next = '0;
                emit      = 1'b1;
                if (len_reg == 2'd3)
                begin
                    push_job.pair  = 1'b1;
                    push_job.unit0 = {plane_m1, 6'd0} | utf8d_pkg::HIGH_SURR_BASE
                                     | {10'd0, bits_cat[15:10]};
                    push_job.unit1 = utf8d_pkg::LOW_SURR_BASE | {6'd0, bits_cat[9:0]};
                end
                else
                begin
                    push_job.unit0 = bits_cat[15:0];
                end
            end
        end
        else
        begin
            // fresh byte; any pending sequence is abandoned
            need_next = 2'd0;
            len_next  = 2'd0;
            bits_next = '0;
            case (s_tdata) inside
                8'h00:
                begin
                end
                [8'h01:8'h7F]:
                begin
                    emit           = 1'b1;
                    push_job.unit0 = {8'd0, s_tdata};
                end
                [8'hC0:8'hDF]:
                begin
                    need_next = 2'd1;
                    len_next  = 2'd1;
                    bits_next = {16'd0, s_tdata[4:0]};
                end
                [8'hE0:8'hEF]:
                begin
                    need_next = 2'd2;
                    len_next  = 2'd2;
                    bits_next = {17'd0, s_tdata[3:0]};
                end
                [8'hF0:8'hF7]:
                begin
                    need_next = 2'd3;
                    len_next  = 2'd3;
                    bits_next = {18'd0, s_tdata[2:0]};
                end
                default:
                begin
                    // stray byte: drop
                end
            endcase
        end
    end

    assign push = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            need_reg <= 2'd0;
            len_reg  <= 2'd0;
            bits_reg <= '0;
        end
        else if (accept)
        begin
            need_reg <= need_next;
            len_reg  <= len_next;
            bits_reg <= bits_next;
        end
    end

endmodule

>>> rtl/utf8d_fifo.sv
// Short job queue between the decoder front end and the output side.
`timescale 1ns / 1ps

module utf8d_fifo
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  utf8d_pkg::job_t     push_job,
    input  logic                pop,
    output logic                full,
    output logic                empty,
    output utf8d_pkg::job_t     head_job
);

    utf8d_pkg::job_t mem [utf8d_pkg::FIFO_DEPTH];

    logic [utf8d_pkg::FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [utf8d_pkg::FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [utf8d_pkg::FIFO_CW-1:0] count_reg, count_next;

    localparam logic [utf8d_pkg::FIFO_AW-1:0] LAST_PTR =
        utf8d_pkg::FIFO_AW'(utf8d_pkg::FIFO_DEPTH - 1);

    assign full     = (count_reg == utf8d_pkg::FIFO_CW'(utf8d_pkg::FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/utf8d_back.sv
// Output side: sends one or two UTF-16 beats for each queued character.
`timescale 1ns / 1ps

module utf8d_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                empty,
    input  utf8d_pkg::job_t     head_job,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // [15:0] code_unit
    output logic                m_tlast    // last_of_run
);

    // set while the low surrogate of a pair is due
    logic phase_reg, phase_next;
    logic take;

    assign m_tvalid = !empty;
    assign m_tdata  = phase_reg ? head_job.unit1 : head_job.unit0;
    assign m_tlast  = phase_reg || !head_job.pair;
    assign take     = m_tvalid && m_tready;
    assign pop      = take && m_tlast;

    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            phase_next = !m_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

>>> rtl/utf8_to_utf16_decoder.sv
// Top level of the streaming UTF-8 to UTF-16 decoder.
//
//   channel   dir   beat contents                      last
//   s_*       in    tdata[7:0]  = in_byte              -
//   m_*       out   tdata[15:0] = code_unit            tlast = last_of_run
//
// One input byte is taken per cycle while the job queue has room; the byte
// that completes a character registers its job in the queue. A surrogate
// pair goes out as two beats, a BMP unit as one. The four-entry job queue
// absorbs output stalls; s_tready drops only when it is full.
// Asynchronous reset clears the pending sequence and empties the queue.
`timescale 1ns / 1ps

module utf8_to_utf16_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] code_unit
    output logic        m_tlast    // last_of_run
);

    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    utf8d_pkg::job_t push_job;
    utf8d_pkg::job_t head_job;

    utf8d_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .full     (full),
        .push     (push),
        .push_job (push_job)
    );

    utf8d_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (full),
        .empty    (empty),
        .head_job (head_job)
    );

    utf8d_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .head_job (head_job),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

>>> rtl/utf8d_checker.sv
// Port-level checks for the UTF-8 to UTF-16 decoder, bound to the top level.
`timescale 1ns / 1ps

module utf8d_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // a stalled output beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // a high surrogate is always followed at once by its low surrogate
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && m_tlast && (m_tdata[15:10] == 6'b110111))
        else $error("high surrogate not followed by low surrogate");

    // nothing is offered right after reset
    assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("output valid right after reset");

    // with the output side empty, no beat appears unless an input byte was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid && !(s_tvalid && s_tready) |=> !m_tvalid)
        else $error("output appeared with no input byte taken");

endmodule

bind utf8_to_utf16_decoder utf8d_checker u_checker (.*);

>>> tb/tb_utf8_to_utf16_decoder.sv
// Self-checking testbench for the UTF-8 to UTF-16 decoder stream.
`timescale 1ns / 1ps

module tb_utf8_to_utf16_decoder;

    localparam logic [7:0] TERMINATOR = 8'h00;
    localparam logic [7:0] ASCII_MAX  = 8'h7F;
    localparam logic [7:0] CONT_MIN   = 8'h80;
    localparam logic [7:0] CONT_MAX   = 8'hBF;
    localparam logic [7:0] LEAD2_MIN  = 8'hC0;
    localparam logic [7:0] LEAD2_MAX  = 8'hDF;
    localparam logic [7:0] LEAD3_MIN  = 8'hE0;
    localparam logic [7:0] LEAD3_MAX  = 8'hEF;
    localparam logic [7:0] LEAD4_MIN  = 8'hF0;
    localparam logic [7:0] LEAD4_MAX  = 8'hF7;
    localparam logic [7:0] BAD_MIN    = 8'hF8;
    localparam logic [7:0] BAD_MAX    = 8'hFF;

    localparam int RANDOM_BYTES   = 400;
    localparam int QUIET_FROM     = 340;
    localparam int WATCHDOG_LIMIT = 2000;

    // Golden decoder plus the queue of code units it has predicted.
    class utf16_scoreboard;
        logic [1:0]  bytes_left;
        logic [1:0]  seq_len;
        logic [20:0] payload;
        logic [15:0] unit_q[$];
        logic        last_q[$];
        int unsigned errors;
        int unsigned bytes_noted;
        int unsigned units_checked;
        int unsigned pairs_predicted;

        function new();
            clear_sequence();
            errors          = 0;
            bytes_noted     = 0;
            units_checked   = 0;
            pairs_predicted = 0;
        endfunction

        function void clear_sequence();
            bytes_left = 2'd0;
            seq_len    = 2'd0;
            payload    = 21'd0;
        endfunction

        function void push_unit(input logic [15:0] unit, input logic last);
            unit_q.push_back(unit);
            last_q.push_back(last);
        endfunction

        // Byte seen with nothing pending.
        function void start_fresh(input logic [7:0] b);
            if (b == TERMINATOR)
                clear_sequence();
            else if (b <= ASCII_MAX)
                push_unit({8'h00, b}, 1'b1);
            else if (b >= LEAD2_MIN && b <= LEAD2_MAX)
            begin
                bytes_left = 2'd1;
                seq_len    = 2'd1;
                payload    = {16'd0, b[4:0]};
            end
            else if (b >= LEAD3_MIN && b <= LEAD3_MAX)
            begin
                bytes_left = 2'd2;
                seq_len    = 2'd2;
                payload    = {17'd0, b[3:0]};
            end
            else if (b >= LEAD4_MIN && b <= LEAD4_MAX)
            begin
                bytes_left = 2'd3;
                seq_len    = 2'd3;
                payload    = {18'd0, b[2:0]};
            end
        endfunction

        function void note_byte(input logic [7:0] b);
            logic [9:0]  plane_m1;
            logic [15:0] high;
            bytes_noted++;
            if (bytes_left == 2'd0)
                start_fresh(b);
            else if (b < CONT_MIN || b > CONT_MAX)
            begin
                // abandon the pending sequence, reprocess as a fresh byte
                clear_sequence();
                start_fresh(b);
            end
            else
            begin
                payload    = {payload[14:0], b[5:0]};
                bytes_left = bytes_left - 2'd1;
                if (bytes_left == 2'd0)
                begin
                    if (seq_len == 2'd3)
                    begin
                        // plane zero wraps to all ones above bit 5
                        plane_m1 = {5'd0, payload[20:16]} - 10'd1;
                        high     = {plane_m1, 6'd0} | utf8d_pkg::HIGH_SURR_BASE
                                   | {10'd0, payload[15:10]};
                        push_unit(high, 1'b0);
                        push_unit(utf8d_pkg::LOW_SURR_BASE | {6'd0, payload[9:0]}, 1'b1);
                        pairs_predicted++;
                    end
                    else
                        push_unit(payload[15:0], 1'b1);
                    clear_sequence();
                end
            end
        endfunction

        function void check_unit(input logic [15:0] unit, input logic last);
            logic [15:0] exp_unit;
            logic        exp_last;
            units_checked++;
            if (unit_q.size() == 0)
            begin
                $display("%0t: unexpected beat, actual unit %h last %b", $time, unit, last);
                errors++;
            end
            else
            begin
                exp_unit = unit_q.pop_front();
                exp_last = last_q.pop_front();
                if (unit !== exp_unit)
                begin
                    $display("%0t: code unit mismatch, expected %h, actual %h",
                             $time, exp_unit, unit);
                    errors++;
                end
                if (last !== exp_last)
                begin
                    $display("%0t: tlast mismatch on unit %h, expected %b, actual %b",
                             $time, exp_unit, exp_last, last);
                    errors++;
                end
            end
        endfunction

        function int outstanding();
            return unit_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] in_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [15:0] code_unit
    logic        m_tlast;   // last_of_run

    utf16_scoreboard sb;
    bit          calm;
    bit          quiet_tail;
    int          sink_stall;
    int          idle_cycles;
    int unsigned broken_runs;

    utf8_to_utf16_decoder i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // Receiver backpressure: random stall bursts of random length.
    always @(negedge clk)
    begin
        if (sink_stall > 0)
        begin
            m_tready <= 1'b0;
            sink_stall--;
        end
        else if (!calm && !quiet_tail && $urandom_range(0, 4) == 0)
        begin
            m_tready   <= 1'b0;
            sink_stall = $urandom_range(0, 7);
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_unit(m_tdata, m_tlast);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d units outstanding",
                     $time, sb.outstanding());
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Present one byte, optionally after a gap, and hold until accepted.
    task automatic send_byte(input logic [7:0] b);
        if (!calm && !quiet_tail && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_byte(b);
        @(negedge clk);
    endtask

    // Hold off the sender until every predicted unit has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (sb.outstanding() != 0);
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'($urandom_range(CONT_MIN, CONT_MAX));
    endfunction

    // One random run: mostly well-formed characters, some noise and breaks.
    task automatic send_random_run(output int sent);
        int          pick;
        int          len;
        int          keep;
        logic [7:0]  lead;
        pick = $urandom_range(0, 99);
        sent = 0;
        if (pick < 30)
        begin
            send_byte(8'($urandom_range(1, ASCII_MAX)));
            sent = 1;
        end
        else if (pick < 80)
        begin
            len  = (pick < 50) ? 1 : (pick < 65) ? 2 : 3;
            lead = (len == 1) ? 8'($urandom_range(LEAD2_MIN, LEAD2_MAX)) :
                   (len == 2) ? 8'($urandom_range(LEAD3_MIN, LEAD3_MAX)) :
                                8'($urandom_range(LEAD4_MIN, LEAD4_MAX));
            send_byte(lead);
            repeat (len) send_byte(cont_byte());
            sent = len + 1;
        end
        else if (pick < 85)
        begin
            send_byte(TERMINATOR);
            sent = 1;
        end
        else if (pick < 90)
        begin
            send_byte($urandom_range(0, 1) ? cont_byte()
                                           : 8'($urandom_range(BAD_MIN, BAD_MAX)));
            sent = 1;
        end
        else
        begin
            // truncate a sequence, then break it with any non-continuation byte
            len  = $urandom_range(1, 3);
            keep = $urandom_range(0, len - 1);
            lead = (len == 1) ? 8'($urandom_range(LEAD2_MIN, LEAD2_MAX)) :
                   (len == 2) ? 8'($urandom_range(LEAD3_MIN, LEAD3_MAX)) :
                                8'($urandom_range(LEAD4_MIN, LEAD4_MAX));
            send_byte(lead);
            repeat (keep) send_byte(cont_byte());
            if ($urandom_range(0, 1))
                send_byte(8'($urandom_range(TERMINATOR, ASCII_MAX)));
            else
                send_byte(8'($urandom_range(LEAD2_MIN, BAD_MAX)));
            sent = keep + 2;
            broken_runs++;
        end
    endtask

    initial
    begin
        logic [7:0] directed [0:24];
        int         random_sent;
        int         run_len;
        bit         paused;

        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        m_tready    = 1'b0;
        calm        = 1'b0;
        quiet_tail  = 1'b0;
        sink_stall  = 0;
        idle_cycles = 0;
        broken_runs = 0;
        random_sent = 0;
        paused      = 1'b0;
        sb          = new();

        // ASCII limits, 2/3/4-byte extremes, plane-zero surrogate, strays,
        // a broken sequence and a terminator in mid-sequence
        directed = '{8'h01, 8'h7F, 8'hC0, 8'h80, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF,
                     8'hF0, 8'h80, 8'h80, 8'h80, 8'hF7, 8'hBF, 8'hBF, 8'hBF,
                     8'h80, 8'hF8, 8'hFF, 8'hE2, 8'h41, 8'hF0, 8'h90, 8'h00};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send_byte(directed[i]);
        drain();

        while (random_sent < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 39) == 0)
                calm = ~calm;
            if (!paused && random_sent >= RANDOM_BYTES / 2)
            begin
                drain();
                paused = 1'b1;
            end
            if (random_sent >= QUIET_FROM)
                quiet_tail = 1'b1;
            send_random_run(run_len);
            random_sent += run_len;
        end

        drain();
        repeat (16) @(posedge clk);

        $display("Decoded %0d bytes (%0d broken sequences) into %0d code units,",
                 sb.bytes_noted, broken_runs, sb.units_checked);
        $display("%0d surrogate pairs; mismatches: %0d, units still outstanding: %0d",
                 sb.pairs_predicted, sb.errors, sb.outstanding());
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/utf8d_pkg.sv
rtl/utf8d_front.sv
rtl/utf8d_fifo.sv
rtl/utf8d_back.sv
rtl/utf8_to_utf16_decoder.sv
rtl/utf8d_checker.sv
tb/tb_utf8_to_utf16_decoder.sv
